[rtl/core/lfu_memo_cache_macros.svh]
// Assertion macros shared by the cache RTL.
`ifndef LFU_MEMO_CACHE_MACROS_SVH
`define LFU_MEMO_CACHE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LFU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define LFU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/lfu_pkg.sv]
// Shared types and constants for the LFU memo cache.
package lfu_pkg;

   localparam int KEY_FIELD_W   = 64;
   localparam int VALUE_FIELD_W = 64;
   localparam int TOTAL_W       = 32;
   localparam int USES_W        = 32;
   localparam int CAP_W         = 5;
   localparam int REQ_DATA_W    = KEY_FIELD_W + VALUE_FIELD_W;
   localparam int RSP_DATA_W    = VALUE_FIELD_W + 2 * TOTAL_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CAP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EVICT_MODE = 1'b1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   // Sequencer to scan unit.
   typedef struct packed {
      logic clear;
      logic en;
   } scan_ctl_type;

   // Scan unit to sequencer.
   typedef struct packed {
      logic hit_found;
      logic vic_found;
      logic free_found;
   } scan_flags_type;

endpackage

[rtl/core/lfu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/lfu_scan.sv]
// Shared compare unit: tracks key match, least used entry and first free slot.
module lfu_scan #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64,
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lfu_pkg::scan_ctl_type    ctl,
   input  logic [IDX_W-1:0]         idx,
   input  logic                     entry_valid,
   input  logic [KEY_BITS-1:0]      entry_key,
   input  logic [VALUE_BITS-1:0]    entry_value,
   input  logic [lfu_pkg::USES_W-1:0] entry_uses,
   input  logic [KEY_BITS-1:0]      lookup_key,
   output lfu_pkg::scan_flags_type  flags,
   output logic [IDX_W-1:0]         hit_idx,
   output logic [VALUE_BITS-1:0]    hit_value,
   output logic [lfu_pkg::USES_W-1:0] hit_uses,
   output logic [IDX_W-1:0]         vic_idx,
   output logic [IDX_W-1:0]         free_idx
);
   import lfu_pkg::*;

   scan_flags_type      flags_ff, flags_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [VALUE_BITS-1:0] hit_value_ff, hit_value_in;
   logic [USES_W-1:0]   hit_uses_ff, hit_uses_in;
   logic [IDX_W-1:0]    vic_idx_ff, vic_idx_in;
   logic [USES_W-1:0]   vic_uses_ff, vic_uses_in;
   logic [KEY_BITS-1:0] vic_key_ff, vic_key_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                better;

   // Lower count wins; equal counts go to the smaller key.
   assign better = !flags_ff.vic_found || (entry_uses < vic_uses_ff) ||
                   ((entry_uses == vic_uses_ff) && (entry_key < vic_key_ff));

   always_comb begin
      flags_in     = flags_ff;
      hit_idx_in   = hit_idx_ff;
      hit_value_in = hit_value_ff;
      hit_uses_in  = hit_uses_ff;
      vic_idx_in   = vic_idx_ff;
      vic_uses_in  = vic_uses_ff;
      vic_key_in   = vic_key_ff;
      free_idx_in  = free_idx_ff;
      if (ctl.clear) begin
         flags_in = '0;
      end else if (ctl.en) begin
         if (entry_valid) begin
            if (!flags_ff.hit_found && (entry_key == lookup_key)) begin
               flags_in.hit_found = 1'b1;
               hit_idx_in         = idx;
               hit_value_in       = entry_value;
               hit_uses_in        = entry_uses;
            end
            if (better) begin
               flags_in.vic_found = 1'b1;
               vic_idx_in         = idx;
               vic_uses_in        = entry_uses;
               vic_key_in         = entry_key;
            end
         end else if (!flags_ff.free_found) begin
            flags_in.free_found = 1'b1;
            free_idx_in         = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      hit_idx_ff   <= hit_idx_in;
      hit_value_ff <= hit_value_in;
      hit_uses_ff  <= hit_uses_in;
      vic_idx_ff   <= vic_idx_in;
      vic_uses_ff  <= vic_uses_in;
      vic_key_ff   <= vic_key_in;
      free_idx_ff  <= free_idx_in;
   end

   assign flags     = flags_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_value = hit_value_ff;
   assign hit_uses  = hit_uses_ff;
   assign vic_idx   = vic_idx_ff;
   assign free_idx  = free_idx_ff;

endmodule

[rtl/core/lfu_memo_cache.sv]
// LFU memo cache top level: request sequencer, entry store and result register.
//
// Usage: each req word is one lookup, carrying a key and the fill value that
// the caller computed for it. Each lookup returns exactly one rsp word: the
// hit flag in rsp_tuser, and in rsp_tdata the stored value on a hit or the
// fill value on a miss, followed by the running hit and lookup totals.
// A hit bumps the entry's use count (saturating). A miss inserts into the
// lowest free slot, or when the cache is full either replaces the least used
// entry (lowest count, then smallest key) or leaves the cache untouched.
// Timing: after a lookup is accepted the block walks all ENTRIES slots of the
// entry RAM, one per cycle through its single read port, and one shared
// compare unit checks each slot. rsp_tvalid rises with the registered result;
// req_tready returns in the same cycle, so a new lookup is only taken once
// the last one commits. The walk length is set by the RAM read port.
// Stall: the result register holds a word until rsp_tready; the next lookup
// is still accepted and runs its scan, then waits before its commit.
// Reset: clears valid bits, occupancy and totals; capacity returns to 16 and
// evict mode to on. The csr port writes a register whenever csr_we is high,
// to be used only while no lookup is in flight.
`include "lfu_memo_cache_macros.svh"

module lfu_memo_cache #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: lookup_key [63:0], fill_value [127:64]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lfu_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: result_value [63:0], hit_total [95:64], probe_total [127:96]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lfu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: hit [0]
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [lfu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lfu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lfu_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int WORD_W = USES_W + VALUE_BITS + KEY_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] fill_ff, fill_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [TOTAL_W-1:0]    hits_ff, hits_in;
   logic [TOTAL_W-1:0]    probes_ff, probes_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic                  evict_ff, evict_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [TOTAL_W-1:0]    rsp_hits_ff, rsp_hits_in;
   logic [TOTAL_W-1:0]    rsp_probes_ff, rsp_probes_in;

   logic                  req_fire;
   logic                  commit;
   logic                  addr_last;
   logic [CMP_W-1:0]      cap_ext;
   logic [CMP_W-1:0]      eff_cap;
   logic                  full;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [WORD_W-1:0]     ram_wdata;
   logic [WORD_W-1:0]     ram_rdata;
   logic [USES_W-1:0]     rd_uses;
   logic [VALUE_BITS-1:0] rd_value;
   logic [KEY_BITS-1:0]   rd_key;
   logic [USES_W-1:0]     hit_uses_next;

   scan_ctl_type          scan_ctl;
   scan_flags_type        scan_flags;
   logic [IDX_W-1:0]      hit_idx;
   logic [VALUE_BITS-1:0] hit_value;
   logic [USES_W-1:0]     hit_uses;
   logic [IDX_W-1:0]      vic_idx;
   logic [IDX_W-1:0]      free_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign addr_last  = (addr_ff == IDX_W'(ENTRIES - 1));
   // Commit only when the result register is free or being drained.
   assign commit     = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_tready);

   // Capacity of zero acts as one; above ENTRIES acts as ENTRIES.
   assign cap_ext = CMP_W'(cap_ff);
   assign eff_cap = (cap_ext == '0) ? CMP_W'(1) :
                    ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
   assign full    = (CMP_W'(occ_ff) >= eff_cap);

   assign {rd_uses, rd_value, rd_key} = ram_rdata;
   assign hit_uses_next = (hit_uses == '1) ? hit_uses : hit_uses + USES_W'(1);

   assign scan_ctl.clear = req_fire;
   assign scan_ctl.en    = cmp_vld_ff;

   lfu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   lfu_scan #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .idx         (cmp_idx_ff),
      .entry_valid (valid_ff[cmp_idx_ff]),
      .entry_key   (rd_key),
      .entry_value (rd_value),
      .entry_uses  (rd_uses),
      .lookup_key  (key_ff),
      .flags       (scan_flags),
      .hit_idx     (hit_idx),
      .hit_value   (hit_value),
      .hit_uses    (hit_uses),
      .vic_idx     (vic_idx),
      .free_idx    (free_idx)
   );

   // Sequencer: accept, walk every slot, drain the compare stage, commit.
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = addr_ff;
      key_in     = key_ff;
      fill_in    = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in   = req_tdata[KEY_BITS-1:0];
               fill_in  = req_tdata[KEY_FIELD_W +: VALUE_BITS];
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            if (addr_last) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commit: update the entry store, totals and the result register.
   always_comb begin
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      hits_in       = hits_ff;
      probes_in     = probes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_hits_in   = rsp_hits_ff;
      rsp_probes_in = rsp_probes_ff;
      ram_we        = 1'b0;
      ram_waddr     = free_idx;
      ram_wdata     = {USES_W'(0), fill_ff, key_ff};
      if (commit) begin
         probes_in     = probes_ff + TOTAL_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_hit_in    = scan_flags.hit_found;
         rsp_probes_in = probes_in;
         if (scan_flags.hit_found) begin
            hits_in      = hits_ff + TOTAL_W'(1);
            rsp_value_in = hit_value;
            ram_we       = 1'b1;
            ram_waddr    = hit_idx;
            ram_wdata    = {hit_uses_next, hit_value, key_ff};
         end else begin
            rsp_value_in = fill_ff;
            if (full) begin
               // Full: replace the least used entry, or leave it all alone.
               if (evict_ff && scan_flags.vic_found) begin
                  ram_we    = 1'b1;
                  ram_waddr = vic_idx;
               end
            end else if (scan_flags.free_found) begin
               ram_we             = 1'b1;
               valid_in[free_idx] = 1'b1;
               occ_in             = occ_ff + CNT_W'(1);
            end
         end
         rsp_hits_in = hits_in;
      end
   end

   always_comb begin
      cap_in   = cap_ff;
      evict_in = evict_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY:   cap_in   = csr_wdata;
            CSR_EVICT_MODE: evict_in = csr_wdata[0];
            default:        cap_in   = cap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         hits_ff      <= '0;
         probes_ff    <= '0;
         cap_ff       <= CAPACITY_RESET;
         evict_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         hits_ff      <= hits_in;
         probes_ff    <= probes_in;
         cap_ff       <= cap_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_idx_ff    <= cmp_idx_in;
      key_ff        <= key_in;
      fill_ff       <= fill_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_probes_ff <= rsp_probes_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {rsp_probes_ff, rsp_hits_ff, VALUE_FIELD_W'(rsp_value_ff)};

   `LFU_ASSERT_NOW(a_occ_matches_valid, clock, reset, 1'b1,
      $countones(valid_ff) == int'(occ_ff), "occupancy disagrees with valid bits")
   `LFU_ASSERT_NOW(a_occ_in_range, clock, reset, 1'b1,
      int'(occ_ff) <= ENTRIES, "occupancy above entry count")
   `LFU_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_fire,
      (state_ff == ST_SCAN) && (addr_ff == '0), "accepted lookup did not start a scan")
   `LFU_ASSERT_NEXT(a_commit_counts_probe, clock, reset, commit,
      rsp_valid_ff && (probes_ff == $past(probes_ff) + TOTAL_W'(1)),
      "commit did not count a lookup")
   `LFU_ASSERT_NEXT(a_hit_counts, clock, reset, commit && scan_flags.hit_found,
      rsp_hit_ff && (hits_ff == $past(hits_ff) + TOTAL_W'(1)),
      "hit not counted")

endmodule
